// File: sv/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 13;
  localparam int ADDR_W   = 24;
  localparam int LEN_W    = 25;
  localparam int CFG_W    = 13;
  localparam int PG_W     = 13;  // managed pages never exceed the 13-bit register
  localparam int WORD_W   = 32;
  localparam int OFF_W    = 5;
  localparam int POS_W    = 6;   // bit position or one past the word
  localparam int WIX_W    = PG_W - OFF_W;

  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd2;

  localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = 13'd4096;
  localparam logic [POS_W-1:0] POS_NONE         = 6'd32;

  // control into the shared word unit
  typedef struct packed {
    logic [OFF_W-1:0] off;    // scan: first bit to look at
    logic [POS_W-1:0] lim;    // scan: bits at or above are out of range
    logic [OFF_W-1:0] lo;     // mark: first bit of the run in this word
    logic [POS_W-1:0] hi;     // mark: one past the last bit
    logic             set;    // mark: 1 occupy, 0 release
  } wu_ctl_t;

  typedef struct packed {
    logic              has_free;
    logic [POS_W-1:0]  f;       // first free bit at or after off
    logic [POS_W-1:0]  b;       // first busy or out-of-range bit at or after f, 32 if none
    logic [WORD_W-1:0] merged;  // word with the mark applied
  } wu_res_t;

  // lowest set bit, 32 when the vector is empty
  function automatic logic [POS_W-1:0] ffs32(input logic [WORD_W-1:0] v);
    logic [POS_W-1:0] r;
    r = POS_NONE;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = POS_W'(i);
    end
    return r;
  endfunction

endpackage

// File: sv/bpa_req_if.sv
`timescale 1ns / 1ps

interface bpa_req_if;
  import bpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COUNT_W-1:0]  page_count;
  logic [ADDR_W-1:0]   address;
  logic [LEN_W-1:0]    byte_length;

  modport source (output valid, action, page_count, address, byte_length, input ready);
  modport sink   (input valid, action, page_count, address, byte_length, output ready);

endinterface

// File: sv/bpa_rsp_if.sv
`timescale 1ns / 1ps

interface bpa_rsp_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [ADDR_W-1:0] run_address;

  modport source (output valid, ok, run_address, input ready);
  modport sink   (input valid, ok, run_address, output ready);

endinterface

// File: sv/bitmap_page_allocator_core.sv
`timescale 1ns / 1ps
// allocate scans the bitmap one word at a time (a word holding several free runs is
//   looked at again), then marks the run word by word; free and reserve set up and clip
//   the page range, then mark it word by word; requests are taken one at a time, ready
//   only while idle, so a new request waits until the last one's result is posted
// reset: all pages occupied; a fill pass writes every bitmap word before the first
//   word is accepted; pages_in_use resets to 4096
module bitmap_page_allocator_core #(
  parameter int PAGES      = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bpa_pkg::CFG_W-1:0] cfg_wdata_i,
  bpa_req_if.sink                  req_i,
  bpa_rsp_if.source                rsp_o
);
  import bpa_pkg::*;

  localparam int WORDS  = (PAGES + WORD_W - 1) / WORD_W;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PBL    = $clog2(PAGE_BYTES);
  localparam int SPW    = ADDR_W - PBL;                    // page of a byte address
  localparam int FW     = (SPW > PG_W) ? SPW : PG_W;       // first page of a run
  localparam int RNW    = LEN_W + 1 - PBL;                 // pages of a reserve range
  localparam int NW     = (RNW > COUNT_W) ? RNW : COUNT_W; // run length
  localparam int EW     = ((FW > NW) ? FW : NW) + 1;       // end of a run
  localparam int PG_CAP = (PAGES > 8191) ? 8191 : PAGES;

  localparam logic [2:0] ST_FILL = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_CLIP = 3'd4;
  localparam logic [2:0] ST_MRD  = 3'd5;
  localparam logic [2:0] ST_MWR  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // control state
  logic [2:0]       state_q, state_d;
  logic [CFG_W-1:0] pages_in_use_q;
  logic [AW-1:0]    fill_q, fill_d;
  logic             rsp_valid_q, rsp_valid_d;

  // working registers
  logic [ACTION_W-1:0] action_q, action_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [FW-1:0]       first_q, first_d;
  logic [NW-1:0]       n_q, n_d;
  logic [WIX_W-1:0]    w_q, w_d;
  logic [OFF_W-1:0]    off_q, off_d;
  logic [PG_W-1:0]     found_q, found_d;
  logic [PG_W-1:0]     start_q, start_d;
  logic [PG_W-1:0]     mfirst_q, mfirst_d;
  logic [PG_W-1:0]     mlast_q, mlast_d;
  logic                pend_ok_q, pend_ok_d;
  logic [ADDR_W-1:0]   pend_run_q, pend_run_d;
  logic                rsp_ok_q, rsp_ok_d;
  logic [ADDR_W-1:0]   rsp_run_q, rsp_run_d;

  // memory port
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] rd_data, wr_data;

  wu_ctl_t wu_ctl;
  wu_res_t wu_res;

  // effective page total
  logic [PG_W-1:0] total;
  assign total = (pages_in_use_q > PG_W'(PG_CAP)) ? PG_W'(PG_CAP) : pages_in_use_q;

  // scan window of the current word
  logic [PG_W-1:0]  wbase, rem;
  logic             last_word;
  logic [PG_W-1:0]  base_len, new_len, run_start;
  logic             cont;

  assign wbase     = {w_q, {OFF_W{1'b0}}};
  assign rem       = total - wbase;
  assign last_word = rem <= PG_W'(WORD_W);
  assign cont      = (found_q != '0) && (wu_res.f == POS_W'(off_q));
  assign base_len  = cont ? found_q : '0;
  assign new_len   = base_len + PG_W'(wu_res.b) - PG_W'(wu_res.f);
  assign run_start = cont ? start_q : (wbase | PG_W'(wu_res.f));

  // range set-up for free and reserve
  logic [LEN_W:0]  rsv_sum;
  logic [EW-1:0]   run_end_raw, run_end, tot_e;
  logic            skip;

  assign rsv_sum     = {1'b0, len_q} + (LEN_W + 1)'(PAGE_BYTES - 1);
  assign tot_e       = EW'(total);
  assign run_end_raw = EW'(first_q) + EW'(n_q);
  assign run_end     = (run_end_raw > tot_e) ? tot_e : run_end_raw;
  assign skip        = (EW'(first_q) >= tot_e) || (n_q == '0);

  // marking window of the current word
  logic is_first_w, is_last_w;
  assign is_first_w = w_q == mfirst_q[PG_W-1:OFF_W];
  assign is_last_w  = w_q == mlast_q[PG_W-1:OFF_W];

  always_comb begin
    wu_ctl.off = off_q;
    wu_ctl.lim = (rem >= PG_W'(WORD_W)) ? POS_NONE : rem[POS_W-1:0];
    wu_ctl.lo  = is_first_w ? mfirst_q[OFF_W-1:0] : '0;
    wu_ctl.hi  = is_last_w ? (POS_W'(mlast_q[OFF_W-1:0]) + POS_W'(1)) : POS_NONE;
    wu_ctl.set = action_q != ACT_FREE;
  end

  bpa_word_unit u_word (
    .word_i (rd_data),
    .ctl_i  (wu_ctl),
    .res_o  (wu_res)
  );

  bpa_bitmap_mem #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign req_i.ready       = state_q == ST_IDLE;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.ok          = rsp_ok_q;
  assign rsp_o.run_address = rsp_run_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rsp_valid_d = rsp_valid_q;
    action_d    = action_q;
    count_d     = count_q;
    addr_d      = addr_q;
    len_d       = len_q;
    first_d     = first_q;
    n_d         = n_q;
    w_d         = w_q;
    off_d       = off_q;
    found_d     = found_q;
    start_d     = start_q;
    mfirst_d    = mfirst_q;
    mlast_d     = mlast_q;
    pend_ok_d   = pend_ok_q;
    pend_run_d  = pend_run_q;
    rsp_ok_d    = rsp_ok_q;
    rsp_run_d   = rsp_run_q;
    rd_en       = 1'b0;
    rd_addr     = AW'(w_q);
    wr_en       = 1'b0;
    wr_addr     = AW'(w_q);
    wr_data     = wu_res.merged;

    // result leaves when taken
    if (rsp_valid_q && rsp_o.ready) rsp_valid_d = 1'b0;

    case (state_q)
      ST_FILL: begin
        // mark every page occupied after reset
        wr_en   = 1'b1;
        wr_addr = fill_q;
        wr_data = '1;
        fill_d  = fill_q + AW'(1);
        if (fill_q == AW'(WORDS - 1)) state_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          action_d   = req_i.action;
          count_d    = req_i.page_count;
          addr_d     = req_i.address;
          len_d      = req_i.byte_length;
          pend_ok_d  = 1'b0;
          pend_run_d = '0;
          w_d        = '0;
          off_d      = '0;
          found_d    = '0;
          case (req_i.action)
            ACT_ALLOC: begin
              if (req_i.page_count == '0) begin
                state_d = ST_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = ST_SCAN;
              end
            end
            ACT_FREE, ACT_RESERVE: begin
              pend_ok_d = 1'b1;
              state_d   = ST_PREP;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_PREP: begin
        first_d = FW'(addr_q[ADDR_W-1:PBL]);
        n_d     = (action_q == ACT_FREE) ? NW'(count_q) : NW'(rsv_sum[LEN_W:PBL]);
        state_d = ST_CLIP;
      end

      ST_SCAN: begin
        if (!wu_res.has_free) begin
          found_d = '0;
          if (last_word) begin
            state_d = ST_DONE;
          end else begin
            w_d     = w_q + WIX_W'(1);
            off_d   = '0;
            rd_en   = 1'b1;
            rd_addr = AW'(w_q + WIX_W'(1));
          end
        end else if (new_len >= count_q) begin
          // run found: mark it through the common path
          first_d    = FW'(run_start);
          n_d        = NW'(count_q);
          pend_ok_d  = 1'b1;
          pend_run_d = ADDR_W'({run_start, {PBL{1'b0}}});
          state_d    = ST_CLIP;
        end else if (wu_res.b == POS_NONE) begin
          // run carries into the next word
          found_d = new_len;
          start_d = run_start;
          if (last_word) begin
            state_d = ST_DONE;
          end else begin
            w_d     = w_q + WIX_W'(1);
            off_d   = '0;
            rd_en   = 1'b1;
            rd_addr = AW'(w_q + WIX_W'(1));
          end
        end else begin
          // run too short, resume after the busy bit in the same word
          found_d = '0;
          off_d   = wu_res.b[OFF_W-1:0];
        end
      end

      ST_CLIP: begin
        if (skip) begin
          state_d = ST_DONE;
        end else begin
          mfirst_d = PG_W'(first_q);
          mlast_d  = PG_W'(run_end - EW'(1));
          w_d      = first_q[PG_W-1:OFF_W];
          state_d  = ST_MRD;
        end
      end

      ST_MRD: begin
        rd_en   = 1'b1;
        state_d = ST_MWR;
      end

      ST_MWR: begin
        // write this word, read the next one alongside
        wr_en = 1'b1;
        if (is_last_w) begin
          state_d = ST_DONE;
        end else begin
          w_d     = w_q + WIX_W'(1);
          rd_en   = 1'b1;
          rd_addr = AW'(w_q + WIX_W'(1));
        end
      end

      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_ok_d    = pend_ok_q;
          rsp_run_d   = pend_run_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_FILL;
      fill_q         <= '0;
      rsp_valid_q    <= 1'b0;
      pages_in_use_q <= PAGES_IN_USE_RST;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) pages_in_use_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    count_q    <= count_d;
    addr_q     <= addr_d;
    len_q      <= len_d;
    first_q    <= first_d;
    n_q        <= n_d;
    w_q        <= w_d;
    off_q      <= off_d;
    found_q    <= found_d;
    start_q    <= start_d;
    mfirst_q   <= mfirst_d;
    mlast_q    <= mlast_d;
    pend_ok_q  <= pend_ok_d;
    pend_run_q <= pend_run_d;
    rsp_ok_q   <= rsp_ok_d;
    rsp_run_q  <= rsp_run_d;
  end

endmodule

// File: sv/bpa_bitmap_mem.sv
`timescale 1ns / 1ps

module bpa_bitmap_mem #(
  parameter int WORDS = 128,
  parameter int AW    = 7
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [bpa_pkg::WORD_W-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [bpa_pkg::WORD_W-1:0] wr_data_i
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/bpa_word_unit.sv
`timescale 1ns / 1ps

module bpa_word_unit (
  input  logic [bpa_pkg::WORD_W-1:0] word_i,
  input  bpa_pkg::wu_ctl_t           ctl_i,
  output bpa_pkg::wu_res_t           res_o
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] in_range;
  logic [WORD_W-1:0] from_off;
  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] from_f;
  logic [WORD_W-1:0] stop_bits;
  logic [WORD_W-1:0] mask;
  logic [POS_W-1:0]  f;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      in_range[i] = POS_W'(i) < ctl_i.lim;
      from_off[i] = OFF_W'(i) >= ctl_i.off;
      mask[i]     = (OFF_W'(i) >= ctl_i.lo) && (POS_W'(i) < ctl_i.hi);
    end
  end

  assign free_bits = ~word_i & in_range & from_off;
  assign f         = ffs32(free_bits);

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      from_f[i] = POS_W'(i) >= f;
    end
  end

  // out-of-range bits end a run like busy ones
  assign stop_bits = ~(~word_i & in_range) & from_f;

  assign res_o.has_free = |free_bits;
  assign res_o.f        = f;
  assign res_o.b        = ffs32(stop_bits);
  assign res_o.merged   = ctl_i.set ? (word_i | mask) : (word_i & ~mask);

endmodule

// File: test/bitmap_page_allocator_core_test.sv
`timescale 1ns / 1ps

module bitmap_page_allocator_core_test;
  import bpa_pkg::*;

  localparam int PAGES      = 4096;
  localparam int PAGE_BYTES = 4096;

  // action code the block has no use for
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  // worst word: a full fragmented scan plus a full mark, well under this
  localparam int IDLE_LIMIT = 40000;
  localparam int PRINT_CAP  = 100;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [COUNT_W-1:0]  page_count;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    byte_length;
  } page_req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] run_address;
  } grant_t;

  // a run handed out by the block, kept so it can be given back later
  typedef struct {
    int unsigned head;
    int unsigned pages;
  } run_t;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_e;

  // occupancy map mirror plus the queue of grants still owed by the block
  class page_map_checker;
    bit               occupied [0:PAGES-1];
    logic [CFG_W-1:0] page_limit;
    grant_t           awaited_grants[$];
    int               mismatches;

    function new();
      foreach (occupied[p]) occupied[p] = 1'b1;
      page_limit = PAGES_IN_USE_RST;
      mismatches = 0;
    endfunction

    function int unsigned managed_pages();
      return (page_limit < PAGES) ? page_limit : PAGES;
    endfunction

    // pages past the managed total are left alone
    function void mark_pages(int unsigned first, int unsigned n, bit busy);
      int unsigned span;
      span = managed_pages();
      if (first >= span) return;
      if (n > span - first) n = span - first;
      for (int unsigned p = first; p < first + n; p++) occupied[p] = busy;
    endfunction

    function grant_t note_request(page_req_t w);
      grant_t      g;
      int unsigned span, found, head, n;
      g = '0;
      case (w.action)
        ACT_ALLOC: begin
          // first fit over managed pages, zero count never fits
          span  = managed_pages();
          found = 0;
          head  = 0;
          for (int unsigned p = 0; p < span && !g.ok && w.page_count != 0; p++) begin
            if (occupied[p]) begin
              found = 0;
            end else begin
              if (found == 0) head = p;
              found++;
              if (found == w.page_count) begin
                mark_pages(head, w.page_count, 1'b1);
                g.ok          = 1'b1;
                g.run_address = ADDR_W'(head * PAGE_BYTES);
              end
            end
          end
        end
        ACT_FREE: begin
          mark_pages(w.address / PAGE_BYTES, w.page_count, 1'b0);
          g.ok = 1'b1;
        end
        ACT_RESERVE: begin
          // length rounds up to whole pages from the page holding the address
          n = (32'(w.byte_length) + PAGE_BYTES - 1) / PAGE_BYTES;
          mark_pages(w.address / PAGE_BYTES, n, 1'b1);
          g.ok = 1'b1;
        end
        default: ;
      endcase
      awaited_grants.push_back(g);
      return g;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_grant(logic ok, logic [ADDR_W-1:0] run_address);
      grant_t want;
      if (awaited_grants.size() == 0) begin
        report($sformatf("word with nothing outstanding, ok %0b run_address %06h",
                         ok, run_address));
      end else begin
        want = awaited_grants.pop_front();
        if (ok !== want.ok)
          report($sformatf("ok %0b, expected %0b", ok, want.ok));
        if (run_address !== want.run_address)
          report($sformatf("run_address %06h, expected %06h", run_address, want.run_address));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bpa_req_if req_w ();
  bpa_rsp_if rsp_w ();

  page_map_checker ledger;
  run_t            live_runs[$];
  int              burst_left;

  bitmap_page_allocator_core #(
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_w),
    .rsp_o       (rsp_w)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // address on a page from 0 up to the managed total (capped at the last page), random
  // offset in the page; now and then anywhere in the 24-bit space
  function automatic logic [ADDR_W-1:0] page_address(int unsigned span);
    int unsigned top;
    if ($urandom_range(0, 7) == 0) return ADDR_W'($urandom);
    top = (span < PAGES) ? span : PAGES - 1;
    return ADDR_W'($urandom_range(0, top) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
  endfunction

  // random word: mostly allocations and the return of runs handed out earlier,
  // some reserves and stray frees, a few unknown actions; unused fields carry noise
  function automatic page_req_t pick_word();
    page_req_t   w;
    run_t        r;
    int unsigned roll, idx, span;
    span          = ledger.managed_pages();
    w.action      = ACT_ALLOC;
    w.page_count  = COUNT_W'($urandom);
    w.address     = ADDR_W'($urandom);
    w.byte_length = LEN_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 42) begin
      case ($urandom_range(0, 19))
        0:       ;  // full-width count, mostly no fit
        1:       w.page_count = '0;
        2, 3:    w.page_count = COUNT_W'($urandom_range(1, 256));
        default: w.page_count = COUNT_W'($urandom_range(1, 16));
      endcase
    end else if (roll < 76) begin
      w.action = ACT_FREE;
      if (live_runs.size() != 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        r   = live_runs[idx];
        live_runs.delete(idx);
        w.address    = ADDR_W'(r.head * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
        w.page_count = COUNT_W'(r.pages);
      end else begin
        w.address = page_address(span);
        if ($urandom_range(0, 9) != 0) w.page_count = COUNT_W'($urandom_range(0, 48));
      end
    end else if (roll < 95) begin
      w.action  = ACT_RESERVE;
      w.address = page_address(span);
      if ($urandom_range(0, 19) != 0)
        w.byte_length = LEN_W'($urandom_range(0, 16 * PAGE_BYTES));
    end else begin
      w.action = ACT_UNKNOWN;
    end
    return w;
  endfunction

  // sender: bursts of back-to-back words, random gaps between bursts;
  // valid stays high across a burst, so it is only lowered when a gap starts
  task automatic send_word(input page_req_t w);
    grant_t g;
    run_t   r;
    if (burst_left == 0) begin
      req_w.valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
    end
    req_w.valid       <= 1'b1;
    req_w.action      <= w.action;
    req_w.page_count  <= w.page_count;
    req_w.address     <= w.address;
    req_w.byte_length <= w.byte_length;
    // values seen here are the ones from before the edge
    do @(posedge clk_i); while (!req_w.ready);
    g = ledger.note_request(w);
    burst_left--;
    if (w.action == ACT_ALLOC && g.ok) begin
      r.head  = g.run_address / PAGE_BYTES;
      r.pages = w.page_count;
      live_runs.push_back(r);
    end
  endtask

  // wait until every grant is back, then let the block settle
  task automatic drain_results();
    req_w.valid <= 1'b0;
    burst_left = 0;
    while (ledger.awaited_grants.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // the page total only changes with the block idle
  task automatic write_page_limit(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    ledger.page_limit = v;
  endtask

  // receiver: stall style is picked anew at random after each stretch, including stretches
  // where ready never drops
  initial begin
    stall_style_e style;
    int           left;
    rsp_w.ready <= 1'b0;
    style = STALL_NONE;
    left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_w.valid && rsp_w.ready) ledger.check_grant(rsp_w.ok, rsp_w.run_address);
      if (left == 0) begin
        style = stall_style_e'($urandom_range(0, 3));
        left  = $urandom_range(20, 400);
      end
      left--;
      case (style)
        STALL_NONE:  rsp_w.ready <= 1'b1;
        STALL_HALF:  rsp_w.ready <= 1'($urandom_range(0, 1));
        STALL_HEAVY: rsp_w.ready <= ($urandom_range(0, 3) == 0);
        default:     rsp_w.ready <= ~rsp_w.ready;
      endcase
    end
  end

  // watchdog: too long with no word moving on either side ends the run
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_w.valid && req_w.ready) || (rsp_w.valid && rsp_w.ready)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] limits [9];
    int unsigned      items;
    ledger = new();
    burst_left = 0;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req_w.valid       <= 1'b0;
    req_w.action      <= '0;
    req_w.page_count  <= '0;
    req_w.address     <= '0;
    req_w.byte_length <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, page total still at its reset value
    // every page starts occupied, so nothing fits
    send_word('{ACT_ALLOC,   13'd1,     24'h000000, 25'd0});
    // zero count always fails
    send_word('{ACT_ALLOC,   13'd0,     24'h000000, 25'd0});
    // zero-length free changes nothing but still succeeds
    send_word('{ACT_FREE,    13'd0,     24'h000000, 25'd0});
    send_word('{ACT_FREE,    13'd4096,  24'h000000, 25'd0});
    // whole map in one run, at page 0 so only ok tells it from a failure
    send_word('{ACT_ALLOC,   13'd4096,  24'h000000, 25'd0});
    send_word('{ACT_ALLOC,   13'd1,     24'h000000, 25'd0});
    // run from the last page runs off the end, only that page is freed
    send_word('{ACT_FREE,    13'h1FFF,  24'hFFFFFF, 25'd0});
    send_word('{ACT_ALLOC,   13'd1,     24'h000000, 25'd0});
    // unaligned free starts at the page holding the address
    send_word('{ACT_FREE,    13'd3,     24'h123456, 25'd0});
    // hole of three pages, four do not fit
    send_word('{ACT_ALLOC,   13'd4,     24'h000000, 25'd0});
    send_word('{ACT_ALLOC,   13'd3,     24'h000000, 25'd0});
    send_word('{ACT_FREE,    13'd16,    24'h000800, 25'd0});
    // zero-length reserve
    send_word('{ACT_RESERVE, 13'd0,     24'h000000, 25'd0});
    // one byte at the end of page 0 takes page 0
    send_word('{ACT_RESERVE, 13'd0,     24'h000FFF, 25'd1});
    // one page plus a byte rounds up to two pages
    send_word('{ACT_RESERVE, 13'd0,     24'h002001, 25'd4097});
    send_word('{ACT_ALLOC,   13'd1,     24'h000000, 25'd0});
    send_word('{ACT_ALLOC,   13'h1FFF,  24'h000000, 25'd0});
    // unknown action, every field at its top
    send_word('{ACT_UNKNOWN, 13'h1FFF,  24'hFFFFFF, 25'h1FFFFFF});
    // range covering the whole map
    send_word('{ACT_RESERVE, 13'd0,     24'h000000, 25'd16777216});
    send_word('{ACT_ALLOC,   13'd1,     24'h000000, 25'd0});
    // longest length from the last byte, clipped at the total
    send_word('{ACT_RESERVE, 13'h1FFF,  24'hFFFFFF, 25'h1FFFFFF});
    send_word('{ACT_FREE,    13'd4096,  24'h000000, 25'd0});

    // random part over several page totals, extremes included;
    // 8191 is above the map, so the map size rules
    limits = '{13'd8, 13'd8191, 13'd0, 13'd1, 13'd100, 13'd4095, 13'd0, 13'd4096, 13'd37};
    limits[6] = CFG_W'($urandom_range(2, PAGES));
    foreach (limits[i]) begin
      write_page_limit(limits[i]);
      // open every managed page so allocation has room to work
      send_word('{ACT_FREE, 13'h1FFF, 24'h000000, 25'd0});
      live_runs.delete();
      items = (limits[i] == 0) ? 40 : 140;
      repeat (items) send_word(pick_word());
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.awaited_grants.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
